// File: src/tdrs_pkg.sv
// shared types, widths and source codes for the torus deflection route selector
// no dependencies
package tdrs_pkg;

  localparam int COORD_BITS = 4;
  localparam int DEST_BITS  = 3 * COORD_BITS;
  localparam int NUM_PORTS  = 3;
  localparam int SRC_BITS   = 3;
  localparam int CFG_IDX_BITS = 2;

  localparam int IN_BITS  = 3 * (1 + DEST_BITS) + NUM_PORTS;
  localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 3 * SRC_BITS + 2 * NUM_PORTS;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  localparam int PORT_X = 0;
  localparam int PORT_Y = 1;
  localparam int PORT_Z = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NODE_X = 2'd0,
    REG_NODE_Y = 2'd1,
    REG_NODE_Z = 2'd2
  } cfg_reg_t;

  typedef enum logic [SRC_BITS-1:0] {
    SRC_XNEG = 3'd0,
    SRC_YNEG = 3'd1,
    SRC_ZNEG = 3'd2,
    SRC_INJ  = 3'd3,
    SRC_IDLE = 3'd4
  } src_t;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DEST_BITS-1:0]  dest_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } node_t;

  typedef struct packed {
    logic live;
    logic eject;
    logic at_x;
    logic at_y;
  } lane_info_t;

  typedef struct packed {
    logic [NUM_PORTS-1:0] free_mask;
    logic [NUM_PORTS-1:0] eject_mask;
    src_t                 zpos_source;
    src_t                 ypos_source;
    src_t                 xpos_source;
  } route_t;

endpackage

// File: src/tdrs_lane.sv
// per-link lane: compares one arriving flit destination against this node
// depends on tdrs_pkg
module tdrs_lane
  import tdrs_pkg::*;
(
  input  logic       flit_valid,
  input  dest_t      flit_dest,
  input  node_t      node,
  output lane_info_t info
);

  coord_t dx, dy, dz;
  logic   at_x, at_y, at_z;

  always_comb begin
    dx = flit_dest[COORD_BITS-1:0];
    dy = flit_dest[2*COORD_BITS-1:COORD_BITS];
    dz = flit_dest[3*COORD_BITS-1:2*COORD_BITS];
    at_x = (dx == node.x);
    at_y = (dy == node.y);
    at_z = (dz == node.z);
    info.eject = flit_valid && at_x && at_y && at_z;
    info.live  = flit_valid && !info.eject;
    info.at_x  = at_x;
    info.at_y  = at_y;
  end

endmodule

// File: src/tdrs_merge.sv
// merge stage: allocates output ports from the three lanes in z, y, x order
// and grants injection on ports left idle; depends on tdrs_pkg
module tdrs_merge
  import tdrs_pkg::*;
(
  input  lane_info_t           lane_x,
  input  lane_info_t           lane_y,
  input  lane_info_t           lane_z,
  input  logic [NUM_PORTS-1:0] inject_request,
  output route_t               route
);

  src_t src_x, src_y, src_z;
  logic [NUM_PORTS-1:0] free_mask;

  always_comb begin
    src_x = SRC_IDLE;
    src_y = SRC_IDLE;
    src_z = SRC_IDLE;

    // z flit always continues on zpos
    if (lane_z.live) begin
      src_z = SRC_ZNEG;
    end

    if (lane_y.live) begin
      if (!lane_y.at_y) begin
        src_y = SRC_YNEG;
      end else if (src_z == SRC_IDLE) begin
        src_z = SRC_YNEG;
      end else begin
        src_y = SRC_YNEG;
      end
    end

    if (lane_x.live) begin
      if (!lane_x.at_x) begin
        src_x = SRC_XNEG;
      end else if (!lane_x.at_y) begin
        if (src_y == SRC_IDLE) begin
          src_y = SRC_XNEG;
        end else begin
          src_x = SRC_XNEG;
        end
      end else if (src_z == SRC_IDLE) begin
        src_z = SRC_XNEG;
      end else if (src_y == SRC_IDLE) begin
        src_y = SRC_XNEG;
      end else begin
        src_x = SRC_XNEG;
      end
    end

    free_mask[PORT_X] = (src_x == SRC_IDLE);
    free_mask[PORT_Y] = (src_y == SRC_IDLE);
    free_mask[PORT_Z] = (src_z == SRC_IDLE);

    route.xpos_source = (free_mask[PORT_X] && inject_request[PORT_X]) ? SRC_INJ : src_x;
    route.ypos_source = (free_mask[PORT_Y] && inject_request[PORT_Y]) ? SRC_INJ : src_y;
    route.zpos_source = (free_mask[PORT_Z] && inject_request[PORT_Z]) ? SRC_INJ : src_z;
    route.free_mask   = free_mask;
    route.eject_mask  = {lane_z.eject, lane_y.eject, lane_x.eject};
  end

endmodule

// File: src/torus_deflection_route_select.sv
// top level of the torus deflection route selector: three lanes, merge, output register
// depends on tdrs_pkg, tdrs_lane, tdrs_merge
//
// channel  dir  handshake                 payload
// s_axis   in   s_tvalid / s_tready       s_tdata  (48 bits, link headers and requests)
// m_axis   out  m_tvalid / m_tready       m_tdata  (16 bits, sources and masks)
// cfg      in   cfg_valid / cfg_ready     cfg_index, cfg_data (node coordinates)
//
// one item per cycle while s_tready stays high; a result appears in the cycle after its input transfer
// latency is set by the single output register behind the lane compare and merge logic
// rst is synchronous, active high; node coordinates reset to zero
// s_tready drops only while a held result is not taken; cfg_ready is always high
module torus_deflection_route_select
  import tdrs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // xneg_valid, xneg_dest, yneg_valid, yneg_dest, zneg_valid, zneg_dest, inject_request
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // xpos_source, ypos_source, zpos_source, eject_mask, inject_free_mask
  output logic [OUT_TDATA_BITS-1:0] m_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]     cfg_data
);

  localparam int XV = 0;
  localparam int XD = XV + 1;
  localparam int YV = XD + DEST_BITS;
  localparam int YD = YV + 1;
  localparam int ZV = YD + DEST_BITS;
  localparam int ZD = ZV + 1;
  localparam int RQ = ZD + DEST_BITS;

  node_t      node;
  lane_info_t lane_x, lane_y, lane_z;
  route_t     route;
  route_t     result;
  logic       in_xfer;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_xfer   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NODE_X: node.x <= cfg_data;
        REG_NODE_Y: node.y <= cfg_data;
        REG_NODE_Z: node.z <= cfg_data;
        default: ;
      endcase
    end
  end

  tdrs_lane u_lane_x (
    .flit_valid (s_tdata[XV]),
    .flit_dest  (s_tdata[XD +: DEST_BITS]),
    .node       (node),
    .info       (lane_x)
  );

  tdrs_lane u_lane_y (
    .flit_valid (s_tdata[YV]),
    .flit_dest  (s_tdata[YD +: DEST_BITS]),
    .node       (node),
    .info       (lane_y)
  );

  tdrs_lane u_lane_z (
    .flit_valid (s_tdata[ZV]),
    .flit_dest  (s_tdata[ZD +: DEST_BITS]),
    .node       (node),
    .info       (lane_z)
  );

  tdrs_merge u_merge (
    .lane_x         (lane_x),
    .lane_y         (lane_y),
    .lane_z         (lane_z),
    .inject_request (s_tdata[RQ +: NUM_PORTS]),
    .route          (route)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result <= route;
    end
  end

  assign m_tdata = {{(OUT_TDATA_BITS - OUT_BITS){1'b0}},
                    result.free_mask, result.eject_mask,
                    result.zpos_source, result.ypos_source, result.xpos_source};

  // injection only lands on a port left free by passthrough
  a_inj_on_free: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((result.xpos_source != SRC_INJ) || result.free_mask[PORT_X]) &&
                 ((result.ypos_source != SRC_INJ) || result.free_mask[PORT_Y]) &&
                 ((result.zpos_source != SRC_INJ) || result.free_mask[PORT_Z]))
    else $error("injection granted on occupied port");

  // a free port carries either nothing or injection
  a_free_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!result.free_mask[PORT_X] || result.xpos_source == SRC_IDLE ||
                  result.xpos_source == SRC_INJ) &&
                 (!result.free_mask[PORT_Y] || result.ypos_source == SRC_IDLE ||
                  result.ypos_source == SRC_INJ) &&
                 (!result.free_mask[PORT_Z] || result.zpos_source == SRC_IDLE ||
                  result.zpos_source == SRC_INJ))
    else $error("free port carries passthrough flit");

  // every live flit takes exactly one output port
  a_flit_count: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> ($countones({lane_x.live, lane_y.live, lane_z.live}) ==
                 NUM_PORTS - $countones(route.free_mask)))
    else $error("flit lost or duplicated");

  // a new transfer never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> (!m_tvalid || m_tready))
    else $error("held result overwritten");

endmodule

// File: tb/sv/tb_torus_deflection_route_select.sv
`timescale 1ns / 1ps
// self-checking bench for torus_deflection_route_select: directed table, then random link traffic
// depends on tdrs_pkg and the torus_deflection_route_select rtl
module tb_torus_deflection_route_select;
  import tdrs_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 106;
  localparam int DIR_ROWS = 16;

  // one set of link headers, packed as on s_tdata, lowest field last
  typedef struct packed {
    logic [NUM_PORTS-1:0] req;
    dest_t                zd;
    logic                 zv;
    dest_t                yd;
    logic                 yv;
    dest_t                xd;
    logic                 xv;
  } links_t;

  typedef struct packed {
    logic                 xv;
    dest_t                xd;
    logic                 yv;
    dest_t                yd;
    logic                 zv;
    dest_t                zd;
    logic [NUM_PORTS-1:0] req;
    logic                 typed;
    src_t                 xs;
    src_t                 ys;
    src_t                 zs;
    logic [NUM_PORTS-1:0] ej;
    logic [NUM_PORTS-1:0] fr;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b1;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index = REG_NODE_X;
  logic [COORD_BITS-1:0]     cfg_data = '0;

  node_t    here = '0;
  route_t   route_q[$];
  route_t   held_want;
  logic     held_typed = 1'b0;
  route_t   got_route;
  route_t   want_route;
  int       err_count = 0;
  int       idle_cycles = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  dir_row_t dir_rows [DIR_ROWS];

  torus_deflection_route_select u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic route_t predict_route(links_t l, node_t node);
    logic [NUM_PORTS-1:0] live;
    logic [NUM_PORTS-1:0] ej;
    dest_t                d [NUM_PORTS];
    src_t                 s [NUM_PORTS];
    node_t                dn;
    route_t               r;
    live = {l.zv, l.yv, l.xv};
    d[PORT_X] = l.xd;
    d[PORT_Y] = l.yd;
    d[PORT_Z] = l.zd;
    for (int i = 0; i < NUM_PORTS; i++) begin
      ej[i] = live[i] && (node_t'(d[i]) == node);
      s[i] = SRC_IDLE;
    end
    // z flit always keeps going on zpos
    if (live[PORT_Z] && !ej[PORT_Z]) s[PORT_Z] = SRC_ZNEG;
    dn = node_t'(d[PORT_Y]);
    if (live[PORT_Y] && !ej[PORT_Y]) begin
      if (dn.y != node.y) s[PORT_Y] = SRC_YNEG;
      else if (s[PORT_Z] == SRC_IDLE) s[PORT_Z] = SRC_YNEG;
      else s[PORT_Y] = SRC_YNEG;
    end
    dn = node_t'(d[PORT_X]);
    if (live[PORT_X] && !ej[PORT_X]) begin
      if (dn.x != node.x) begin
        s[PORT_X] = SRC_XNEG;
      end else if (dn.y != node.y) begin
        if (s[PORT_Y] == SRC_IDLE) s[PORT_Y] = SRC_XNEG;
        else s[PORT_X] = SRC_XNEG;
      end else begin
        if (s[PORT_Z] == SRC_IDLE) s[PORT_Z] = SRC_XNEG;
        else if (s[PORT_Y] == SRC_IDLE) s[PORT_Y] = SRC_XNEG;
        else s[PORT_X] = SRC_XNEG;
      end
    end
    for (int i = 0; i < NUM_PORTS; i++) begin
      r.free_mask[i] = (s[i] == SRC_IDLE);
      if (r.free_mask[i] && l.req[i]) s[i] = SRC_INJ;
    end
    r.eject_mask = ej;
    r.xpos_source = s[PORT_X];
    r.ypos_source = s[PORT_Y];
    r.zpos_source = s[PORT_Z];
    return r;
  endfunction

  // destinations lean toward this node's coordinates so turns and ejections happen often
  function automatic dest_t rand_dest(node_t node);
    node_t d;
    d = node_t'($urandom);
    if ($urandom_range(6) != 0) begin
      if ($urandom_range(1) != 0) d.x = node.x;
      if ($urandom_range(1) != 0) d.y = node.y;
      if ($urandom_range(1) != 0) d.z = node.z;
    end
    return dest_t'(d);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    err_count++;
  endtask

  task automatic send_links(links_t l);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_TDATA_BITS'(l);
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic load_node(node_t n);
    cfg_reg_t r;
    r = REG_NODE_X;
    repeat (NUM_PORTS) begin
      cfg_valid <= 1'b1;
      cfg_index <= r;
      case (r)
        REG_NODE_X: cfg_data <= n.x;
        REG_NODE_Y: cfg_data <= n.y;
        default:    cfg_data <= n.z;
      endcase
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
      r = r.next();
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (route_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        route_q.push_back(held_typed ? held_want
                                     : predict_route(links_t'(s_tdata[IN_BITS-1:0]), here));
      end
      if (m_tvalid && m_tready) begin
        got_route = route_t'(m_tdata[OUT_BITS-1:0]);
        if (route_q.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(m_tdata), 32'd0);
        end else begin
          want_route = route_q.pop_front();
          if (got_route.xpos_source !== want_route.xpos_source)
            report_mismatch("xpos_source", 32'(got_route.xpos_source), 32'(want_route.xpos_source));
          if (got_route.ypos_source !== want_route.ypos_source)
            report_mismatch("ypos_source", 32'(got_route.ypos_source), 32'(want_route.ypos_source));
          if (got_route.zpos_source !== want_route.zpos_source)
            report_mismatch("zpos_source", 32'(got_route.zpos_source), 32'(want_route.zpos_source));
          if (got_route.eject_mask !== want_route.eject_mask)
            report_mismatch("eject_mask", 32'(got_route.eject_mask), 32'(want_route.eject_mask));
          if (got_route.free_mask !== want_route.free_mask)
            report_mismatch("inject_free_mask", 32'(got_route.free_mask), 32'(want_route.free_mask));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NODE_X: here.x = cfg_data;
          REG_NODE_Y: here.y = cfg_data;
          REG_NODE_Z: here.z = cfg_data;
          default: ;
        endcase
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    links_t l;
    node_t  node;
    // node sits at reset coordinates (0,0,0) for the directed rows
    dir_rows = '{
      '{1'b0, 12'h000, 1'b0, 12'h000, 1'b0, 12'h000, 3'd0,
        1'b1, SRC_IDLE, SRC_IDLE, SRC_IDLE, 3'd0, 3'd7},
      '{1'b0, 12'hFFF, 1'b0, 12'hFFF, 1'b0, 12'hFFF, 3'd7,
        1'b1, SRC_INJ, SRC_INJ, SRC_INJ, 3'd0, 3'd7},
      '{1'b1, 12'h000, 1'b1, 12'h000, 1'b1, 12'h000, 3'd0,
        1'b1, SRC_IDLE, SRC_IDLE, SRC_IDLE, 3'd7, 3'd7},
      '{1'b1, 12'hFFF, 1'b1, 12'hFFF, 1'b1, 12'hFFF, 3'd7,
        1'b1, SRC_XNEG, SRC_YNEG, SRC_ZNEG, 3'd0, 3'd0},
      '{1'b1, 12'h000, 1'b1, 12'h000, 1'b1, 12'h000, 3'd7,
        1'b1, SRC_INJ, SRC_INJ, SRC_INJ, 3'd7, 3'd7},
      // z flit already at its z but elsewhere
      '{1'b0, 12'h000, 1'b0, 12'h000, 1'b1, 12'h0F0, 3'd0,
        1'b0, SRC_IDLE, SRC_IDLE, SRC_IDLE, 3'd0, 3'd0},
      // y flit at its y turns to z even with x off
      '{1'b0, 12'h000, 1'b1, 12'h00F, 1'b0, 12'h000, 3'd3,
        1'b0, SRC_IDLE, SRC_IDLE, SRC_IDLE, 3'd0, 3'd0},
      '{1'b0, 12'h000, 1'b1, 12'h00F, 1'b1, 12'hFFF, 3'd0,
        1'b0, SRC_IDLE, SRC_IDLE, SRC_IDLE, 3'd0, 3'd0},
      '{1'b1, 12'h0F0, 1'b0, 12'h000, 1'b0, 12'h000, 3'd5,
        1'b0, SRC_IDLE, SRC_IDLE, SRC_IDLE, 3'd0, 3'd0},
      '{1'b1, 12'h0F0, 1'b1, 12'h0F0, 1'b0, 12'h000, 3'd4,
        1'b0, SRC_IDLE, SRC_IDLE, SRC_IDLE, 3'd0, 3'd0},
      '{1'b1, 12'hF00, 1'b0, 12'h000, 1'b0, 12'h000, 3'd3,
        1'b0, SRC_IDLE, SRC_IDLE, SRC_IDLE, 3'd0, 3'd0},
      '{1'b1, 12'hF00, 1'b0, 12'h000, 1'b1, 12'hFFF, 3'd1,
        1'b0, SRC_IDLE, SRC_IDLE, SRC_IDLE, 3'd0, 3'd0},
      '{1'b1, 12'hF00, 1'b1, 12'h0F0, 1'b1, 12'hFFF, 3'd0,
        1'b0, SRC_IDLE, SRC_IDLE, SRC_IDLE, 3'd0, 3'd0},
      '{1'b1, 12'hF00, 1'b1, 12'h00F, 1'b0, 12'h000, 3'd1,
        1'b0, SRC_IDLE, SRC_IDLE, SRC_IDLE, 3'd0, 3'd0},
      '{1'b1, 12'h000, 1'b1, 12'hFFF, 1'b0, 12'h000, 3'd1,
        1'b0, SRC_IDLE, SRC_IDLE, SRC_IDLE, 3'd0, 3'd0},
      '{1'b1, 12'h0FF, 1'b0, 12'h5A3, 1'b1, 12'h000, 3'd6,
        1'b0, SRC_IDLE, SRC_IDLE, SRC_IDLE, 3'd0, 3'd0}
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      l.xv = dir_rows[i].xv;
      l.xd = dir_rows[i].xd;
      l.yv = dir_rows[i].yv;
      l.yd = dir_rows[i].yd;
      l.zv = dir_rows[i].zv;
      l.zd = dir_rows[i].zd;
      l.req = dir_rows[i].req;
      held_typed = dir_rows[i].typed;
      held_want.xpos_source = dir_rows[i].xs;
      held_want.ypos_source = dir_rows[i].ys;
      held_want.zpos_source = dir_rows[i].zs;
      held_want.eject_mask = dir_rows[i].ej;
      held_want.free_mask = dir_rows[i].fr;
      send_links(l);
    end
    held_typed = 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: node = '1;
        1: node = '0;
        2: node = '{z: 4'd15, y: 4'd0, x: 4'd7};
        default: node = node_t'($urandom);
      endcase
      load_node(node);
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 61; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 61; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        l.xv = ($urandom_range(3) != 0);
        l.xd = rand_dest(node);
        l.yv = ($urandom_range(3) != 0);
        l.yd = rand_dest(node);
        l.zv = ($urandom_range(3) != 0);
        l.zd = rand_dest(node);
        l.req = NUM_PORTS'($urandom_range(7));
        send_links(l);
      end
    end
    drain();

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
